@@ hdl/aes128_block_cipher_macros.svh @@
// Assertion macros shared by the AES-128 RTL.
`ifndef AES128_BLOCK_CIPHER_MACROS_SVH
`define AES128_BLOCK_CIPHER_MACROS_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication, checked at every rising edge outside reset.
`define AES_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication.
`define AES_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define AES_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)
`define AES_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

@@ hdl/aes128_pkg.sv @@
`timescale 1ns / 1ps
package aes128_pkg;

    localparam int NUM_ROUNDS = 10;
    localparam int IDX_W      = 2;

    localparam logic [IDX_W-1:0] REG_KEY_HIGH = 2'd0;
    localparam logic [IDX_W-1:0] REG_KEY_LOW  = 2'd1;

    typedef logic [127:0] t_state;

    typedef struct packed {
        logic valid;
        logic action;   // 0 encrypt, 1 decrypt
    } t_cell_ctl;

    typedef struct packed {
        logic busy;
    } t_key_status;

    localparam logic [7:0] SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    localparam logic [7:0] INV_SBOX [256] = '{
        8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
        8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
        8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
        8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
        8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
        8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
        8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
        8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
        8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
        8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
        8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
        8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
        8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
        8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
        8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
        8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
    };

    function automatic logic [7:0] xtime(logic [7:0] x);
        return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
    endfunction

    // State byte i sits at bits 127-8i down.
    function automatic t_state sub_shift_fwd(t_state s);
        t_state o;
        o = '0;
        for (int r = 0; r < 4; r++) begin
            for (int c = 0; c < 4; c++) begin
                o[127-8*(r+4*c) -: 8] = SBOX[s[127-8*(r+4*((c+r)&3)) -: 8]];
            end
        end
        return o;
    endfunction

    function automatic t_state sub_shift_inv(t_state s);
        t_state o;
        o = '0;
        for (int r = 0; r < 4; r++) begin
            for (int c = 0; c < 4; c++) begin
                o[127-8*(r+4*((c+r)&3)) -: 8] = INV_SBOX[s[127-8*(r+4*c) -: 8]];
            end
        end
        return o;
    endfunction

    function automatic t_state mix_fwd(t_state s);
        t_state     o;
        logic [7:0] a [4];
        o = '0;
        for (int c = 0; c < 4; c++) begin
            for (int k = 0; k < 4; k++) begin
                a[k] = s[127-8*(4*c+k) -: 8];
            end
            for (int r = 0; r < 4; r++) begin
                o[127-8*(4*c+r) -: 8] = xtime(a[r]) ^ xtime(a[(r+1)&3]) ^ a[(r+1)&3]
                                      ^ a[(r+2)&3] ^ a[(r+3)&3];
            end
        end
        return o;
    endfunction

    function automatic t_state mix_inv(t_state s);
        t_state     o;
        logic [7:0] a  [4];
        logic [7:0] x2 [4];
        logic [7:0] x4 [4];
        logic [7:0] x8 [4];
        o = '0;
        for (int c = 0; c < 4; c++) begin
            for (int k = 0; k < 4; k++) begin
                a[k]  = s[127-8*(4*c+k) -: 8];
                x2[k] = xtime(a[k]);
                x4[k] = xtime(x2[k]);
                x8[k] = xtime(x4[k]);
            end
            // coefficients 0e 0b 0d 09 along the row
            for (int r = 0; r < 4; r++) begin
                o[127-8*(4*c+r) -: 8] =
                    (x8[r] ^ x4[r] ^ x2[r])
                  ^ (x8[(r+1)&3] ^ x2[(r+1)&3] ^ a[(r+1)&3])
                  ^ (x8[(r+2)&3] ^ x4[(r+2)&3] ^ a[(r+2)&3])
                  ^ (x8[(r+3)&3] ^ a[(r+3)&3]);
            end
        end
        return o;
    endfunction

endpackage

@@ hdl/aes128_key_sched.sv @@
`timescale 1ns / 1ps
`include "aes128_block_cipher_macros.svh"
module aes128_key_sched
    import aes128_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [IDX_W-1:0]           i_cfg_index,
    input  logic [63:0]                i_cfg_data,
    output logic [NUM_ROUNDS:0][127:0] o_round_keys,
    output t_key_status                o_status
);

    logic [NUM_ROUNDS:0][127:0] r_rk;
    logic [127:0]               r_work;
    logic [7:0]                 r_rcon;
    logic [3:0]                 r_cnt;
    logic                       r_busy;
    logic [127:0]               n_work;
    logic [31:0]                w_t;
    logic [31:0]                w_n0, w_n1, w_n2, w_n3;

    // RotWord, SubWord and round constant on the last word
    always_comb begin
        w_t  = {SBOX[r_work[23:16]] ^ r_rcon, SBOX[r_work[15:8]],
                SBOX[r_work[7:0]], SBOX[r_work[31:24]]};
        w_n0 = r_work[127:96] ^ w_t;
        w_n1 = r_work[95:64]  ^ w_n0;
        w_n2 = r_work[63:32]  ^ w_n1;
        w_n3 = r_work[31:0]   ^ w_n2;
        n_work = {w_n0, w_n1, w_n2, w_n3};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rk[0] <= '0;
            r_work  <= '0;
            r_rcon  <= 8'h01;
            r_cnt   <= 4'd1;
            r_busy  <= 1'b1;
        end else if (i_cfg_we && (i_cfg_index == REG_KEY_HIGH ||
                                  i_cfg_index == REG_KEY_LOW)) begin
            // restart the expansion from the new key
            if (i_cfg_index == REG_KEY_HIGH) begin
                r_rk[0][127:64] <= i_cfg_data;
                r_work          <= {i_cfg_data, r_rk[0][63:0]};
            end else begin
                r_rk[0][63:0] <= i_cfg_data;
                r_work        <= {r_rk[0][127:64], i_cfg_data};
            end
            r_rcon <= 8'h01;
            r_cnt  <= 4'd1;
            r_busy <= 1'b1;
        end else if (r_busy) begin
            r_rk[r_cnt] <= n_work;
            r_work      <= n_work;
            r_rcon      <= xtime(r_rcon);
            r_cnt       <= r_cnt + 4'd1;
            if (r_cnt == 4'(NUM_ROUNDS)) begin
                r_busy <= 1'b0;
            end
        end
    end

    assign o_round_keys  = r_rk;
    assign o_status.busy = r_busy;

    `AES_ASSERT_IMPLY(a_cnt_range, i_clk, i_rst_n, r_busy,
        r_cnt >= 4'd1 && r_cnt <= 4'(NUM_ROUNDS))
    `AES_ASSERT_IMPLY(a_done_at_last, i_clk, i_rst_n, $fell(r_busy),
        $past(r_cnt) == 4'(NUM_ROUNDS))
    `AES_ASSERT_NEXT(a_cfg_restarts, i_clk, i_rst_n, i_cfg_we && i_cfg_index == REG_KEY_LOW,
        r_busy && r_cnt == 4'd1)

endmodule

@@ hdl/aes128_round_cell.sv @@
`timescale 1ns / 1ps
`include "aes128_block_cipher_macros.svh"
module aes128_round_cell
    import aes128_pkg::*;
#(
    parameter bit LAST = 1'b0
)(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_adv,
    input  t_cell_ctl    i_ctl,
    input  t_state       i_state,
    input  logic [127:0] i_key_enc,
    input  logic [127:0] i_key_dec,
    output t_cell_ctl    o_ctl,
    output t_state       o_state
);

    t_cell_ctl r_ctl;
    t_state    r_state;
    t_state    n_state;
    t_state    w_enc;
    t_state    w_dec;

    always_comb begin
        w_enc = sub_shift_fwd(i_state);
        if (!LAST) begin
            w_enc = mix_fwd(w_enc);
        end
        w_enc = w_enc ^ i_key_enc;
        w_dec = sub_shift_inv(i_state) ^ i_key_dec;
        if (!LAST) begin
            w_dec = mix_inv(w_dec);
        end
        n_state = i_ctl.action ? w_dec : w_enc;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else if (i_adv) begin
            r_ctl <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_state <= n_state;
        end
    end

    assign o_ctl   = r_ctl;
    assign o_state = r_state;

    `AES_ASSERT_NEXT(a_hold_valid, i_clk, i_rst_n, !i_adv, $stable(r_ctl))
    `AES_ASSERT_NEXT(a_take_valid, i_clk, i_rst_n, i_adv, r_ctl == $past(i_ctl))
    `AES_ASSERT_NEXT(a_hold_state, i_clk, i_rst_n, !i_adv && r_ctl.valid, $stable(r_state))

endmodule

@@ hdl/aes128_block_cipher.sv @@
`timescale 1ns / 1ps
// AES-128 ECB engine (FIPS-197, 10 rounds). Each transfer on the input carries one 128-bit
// block and a direction bit (0 encrypt, 1 decrypt); each output transfer returns the result,
// in order. Byte 0 of the block sits in bits 63:56 of the high half. The engine is an
// initial key-add stage followed by a chain of ten round cells, one pipeline register each,
// so it takes one block per cycle while the input is not stalled, and each result leaves
// from the last cell's register; the whole chain freezes while a finished result waits on
// the output. The key is written through two 64-bit registers (index 0 high half, index 1
// low half). Each key write, and reset, starts a round key expansion during which the input
// is stalled; write the key only while no block is in flight.
`include "aes128_block_cipher_macros.svh"
module aes128_block_cipher
    import aes128_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    // configuration
    input  logic             i_cfg_we,
    input  logic [IDX_W-1:0] i_cfg_index,
    input  logic [63:0]      i_cfg_data,
    // input channel
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  logic             i_action,
    input  logic [63:0]      i_block_high,
    input  logic [63:0]      i_block_low,
    // output channel
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output logic [63:0]      o_out_high,
    output logic [63:0]      o_out_low
);

    logic [NUM_ROUNDS:0][127:0] w_rk;
    t_key_status                w_key;

    // stage 0 is the initial AddRoundKey; stages 1..10 are round cells
    t_cell_ctl                  w_ctl   [NUM_ROUNDS+1];
    t_state                     w_state [NUM_ROUNDS+1];
    t_cell_ctl                  r_ctl0;
    t_state                     r_state0;
    t_state                     n_state0;

    logic                       w_adv;
    logic                       w_in_xfer;

    aes128_key_sched u_key_sched (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_round_keys (w_rk),
        .o_status     (w_key)
    );

    // Advance the whole chain unless a result sits on the output and is stalled.
    assign w_adv      = !(w_ctl[NUM_ROUNDS].valid && i_out_stall);
    // Hold off new blocks while the round keys are being rebuilt or the chain is frozen.
    assign o_in_stall = w_key.busy || !w_adv;
    assign w_in_xfer  = i_in_valid && !o_in_stall;

    // Whitening: encrypt starts with the first round key, decrypt with the last.
    assign n_state0 = {i_block_high, i_block_low} ^ (i_action ? w_rk[NUM_ROUNDS] : w_rk[0]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl0 <= '0;
        end else if (w_adv) begin
            r_ctl0.valid  <= w_in_xfer;
            r_ctl0.action <= i_action;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_state0 <= n_state0;
        end
    end

    assign w_ctl[0]   = r_ctl0;
    assign w_state[0] = r_state0;

    // Round cell k uses round key k to encrypt and round key 10-k to decrypt.
    for (genvar k = 1; k <= NUM_ROUNDS; k++) begin : g_round
        aes128_round_cell #(
            .LAST (k == NUM_ROUNDS)
        ) u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_adv     (w_adv),
            .i_ctl     (w_ctl[k-1]),
            .i_state   (w_state[k-1]),
            .i_key_enc (w_rk[k]),
            .i_key_dec (w_rk[NUM_ROUNDS-k]),
            .o_ctl     (w_ctl[k]),
            .o_state   (w_state[k])
        );
    end

    // The last cell's register is the output register.
    assign o_out_valid = w_ctl[NUM_ROUNDS].valid;
    assign o_out_high  = w_state[NUM_ROUNDS][127:64];
    assign o_out_low   = w_state[NUM_ROUNDS][63:0];

    `AES_ASSERT_IMPLY(a_no_xfer_busy, i_clk, i_rst_n, w_in_xfer, !w_key.busy && w_adv)
    `AES_ASSERT_NEXT(a_stalled_out_holds, i_clk, i_rst_n, !w_adv, o_out_valid)
    `AES_ASSERT_NEXT(a_xfer_enters, i_clk, i_rst_n, w_in_xfer, r_ctl0.valid)

endmodule
